@@ sv/speed_profile_time_interpolator_defines.svh @@
// ---------------------------------------------------------------------------
// speed profile time interpolator assertion macros
// ---------------------------------------------------------------------------
`ifndef SPEED_PROFILE_TIME_INTERPOLATOR_DEFINES_SVH
`define SPEED_PROFILE_TIME_INTERPOLATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SPTI_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define SPTI_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define SPTI_ASSERT(label, prop)
`define SPTI_ASSERT_RST(label, prop)
`endif
`endif

@@ sv/spti_pkg.sv @@
// ---------------------------------------------------------------------------
// spti_pkg
// types and constants of the speed profile time interpolator
// ---------------------------------------------------------------------------
package spti_pkg;
  localparam int MaxPoints = 256;
  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW = AddrW + 1;

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;
  localparam logic [1:0] OpNop = 2'd3;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StFew = 3'd1;
  localparam logic [2:0] StRange = 3'd2;
  localparam logic [2:0] StFull = 3'd3;
  localparam logic [2:0] StOrder = 3'd4;

  typedef struct packed {
    logic [31:0] t;
    logic [31:0] d;
    logic [31:0] v;
    logic [31:0] a;
    logic [31:0] j;
  } point_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDLAST, S_RDFIRST, S_CHECK, S_SRCH, S_SRCHW, S_RDP1, S_RDP0,
    S_WAITP0, S_MUL, S_DIV, S_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] mag;
    logic [31:0] den;
  } div_req_t;
endpackage

@@ sv/spti_point_ram.sv @@
// ---------------------------------------------------------------------------
// spti_point_ram
// point table, one write and one read port, registered read data
// ---------------------------------------------------------------------------
module spti_point_ram (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [spti_pkg::AddrW-1:0] waddr_i,
  input  spti_pkg::point_t       wdata_i,
  input  logic [spti_pkg::AddrW-1:0] raddr_i,
  output spti_pkg::point_t       rdata_o
);
  import spti_pkg::*;
  point_t mem [MaxPoints];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ sv/spti_divider.sv @@
// ---------------------------------------------------------------------------
// spti_divider
// restoring divider, 64 by 32 bits, one quotient bit a cycle
// ---------------------------------------------------------------------------
module spti_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spti_pkg::div_req_t req_i,
  output logic               done_o,
  output logic [63:0]        quo_o
);
  import spti_pkg::*;
  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;

  assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q <= 7'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.mag;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q;
endmodule

@@ sv/speed_profile_time_interpolator.sv @@
// ---------------------------------------------------------------------------
// speed_profile_time_interpolator
// speed point table with time query and linear interpolation
// ---------------------------------------------------------------------------
// in channel: in_valid_i / in_stall_o with opcode and point fields; out
// channel: out_valid_o / out_stall_i with status, point and table fields.
// append: points in nondecreasing time order, 256 at most.
// query: binary search over the time column, then the four quantities are
// interpolated one after another through a single serial divider.
// clear: empties the table.
// one beat in, one beat out. a query runs the binary search and then the
// serial divider once per quantity, one quotient bit a cycle.
// one item at a time: in_stall_o is high from acceptance until the result
// has left the output register; a stalled result holds.
// reset empties the table; the table memory is not cleared.
// ---------------------------------------------------------------------------
module speed_profile_time_interpolator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] point_time_i,
  input  logic signed [31:0] point_dist_i,
  input  logic signed [31:0] point_speed_i,
  input  logic signed [31:0] point_accel_i,
  input  logic signed [31:0] point_jerk_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] res_time_o,
  output logic signed [31:0] res_dist_o,
  output logic signed [31:0] res_speed_o,
  output logic signed [31:0] res_accel_o,
  output logic signed [31:0] res_jerk_o,
  output logic [31:0] span_time_o,
  output logic [8:0]  stored_count_o
);
  import spti_pkg::*;
  `include "speed_profile_time_interpolator_defines.svh"

  state_e state_q, state_d;
  logic [CntW-1:0] total_q;
  logic [1:0]  op_q;
  point_t      in_q;
  logic [31:0] first_q, last_q;
  logic [CntW-1:0] lo_q, hi_q;
  point_t      p1_q, p0_q;
  logic [1:0]  qi_q;
  logic        neg_q, zero_q;
  logic [31:0] den_q, num_q;
  logic [31:0] res_q [4];
  logic [2:0]  st_q, st_d;

  logic        we;
  logic [AddrW-1:0] waddr, raddr;
  point_t      rdata;
  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dquo;
  logic [CntW-1:0] mid;
  logic [31:0] x0, x1;
  logic signed [32:0] diff;
  logic [32:0] absd;
  logic [63:0] prod;

  spti_point_ram u_ram (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(in_q),
                        .raddr_i(raddr), .rdata_o(rdata));
  spti_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quo_o(dquo));

  assign mid = CntW'((lo_q + hi_q) >> 1);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    case (qi_q)
      2'd0: begin x0 = p0_q.d; x1 = p1_q.d; end
      2'd1: begin x0 = p0_q.v; x1 = p1_q.v; end
      2'd2: begin x0 = p0_q.a; x1 = p1_q.a; end
      default: begin x0 = p0_q.j; x1 = p1_q.j; end
    endcase
    diff = $signed({x1[31], x1}) - $signed({x0[31], x0});
    absd = diff[32] ? 33'(-diff) : 33'(diff);
    prod = 64'(absd[31:0]) * 64'(num_q) + (absd[32] ? {num_q, 32'd0} : 64'd0);
  end

  always_comb begin
    st_d = StOk;
    if (op_q == OpAppend) begin
      if (total_q >= CntW'(MaxPoints)) st_d = StFull;
      else if (total_q != '0 && in_q.t < last_q) st_d = StOrder;
    end else if (op_q == OpQuery) begin
      if (total_q < CntW'(2)) st_d = StFew;
      else if (in_q.t < rdata.t || in_q.t > last_q) st_d = StRange;
    end
  end

  always_comb begin
    raddr = AddrW'(total_q - CntW'(1));
    case (state_q)
      S_RDFIRST: raddr = '0;
      S_SRCH: raddr = mid[AddrW-1:0];
      S_RDP1: raddr = lo_q[AddrW-1:0];
      S_RDP0: raddr = AddrW'(lo_q - CntW'(1));
      default: raddr = AddrW'(total_q - CntW'(1));
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RDLAST;
      S_RDLAST: state_d = S_RDFIRST;
      S_RDFIRST: state_d = S_CHECK;
      S_CHECK: begin
        if (op_q == OpQuery && st_d == StOk) state_d = S_SRCH;
        else state_d = S_OUT;
      end
      S_SRCH: state_d = (lo_q < hi_q) ? S_SRCHW : S_RDP1;
      S_SRCHW: state_d = S_SRCH;
      S_RDP1: state_d = S_RDP0;
      S_RDP0: state_d = S_WAITP0;
      S_WAITP0: state_d = (lo_q == '0) ? S_OUT : S_MUL;
      S_MUL: state_d = S_DIV;
      S_DIV: if (ddone) state_d = (qi_q == 2'd3) ? S_OUT : S_MUL;
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    we = (state_q == S_CHECK) && (op_q == OpAppend) && (st_d == StOk);
    waddr = total_q[AddrW-1:0];
    dreq.start = (state_q == S_MUL);
    dreq.mag = prod;
    dreq.den = den_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      if (we) total_q <= total_q + CntW'(1);
      if (state_q == S_CHECK && op_q == OpClear) total_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q <= opcode_i;
        in_q <= '{point_time_i, point_dist_i, point_speed_i, point_accel_i, point_jerk_i};
        lo_q <= '0;
        hi_q <= '0;
      end
      S_RDFIRST: begin
        last_q <= rdata.t;
        hi_q <= total_q;
      end
      S_CHECK: begin
        first_q <= (we && total_q == '0) ? in_q.t : rdata.t;
        for (int i = 0; i < 4; i++) res_q[i] <= '0;
        st_q <= st_d;
        if (we) last_q <= in_q.t;
        p1_q.t <= '0;
      end
      S_SRCHW: begin
        if (rdata.t < in_q.t) lo_q <= mid + CntW'(1);
        else hi_q <= mid;
      end
      S_RDP0: p1_q <= rdata;
      S_WAITP0: begin
        p0_q <= rdata;
        qi_q <= 2'd0;
        num_q <= in_q.t - rdata.t;
        den_q <= p1_q.t - rdata.t;
        if (lo_q == '0) begin
          res_q[0] <= p1_q.d;
          res_q[1] <= p1_q.v;
          res_q[2] <= p1_q.a;
          res_q[3] <= p1_q.j;
        end
      end
      S_MUL: begin
        neg_q <= diff[32];
        zero_q <= (qi_q != 2'd0) && (x0 == '0 || x1 == '0);
      end
      S_DIV: if (ddone) begin
        res_q[qi_q] <= zero_q ? 32'd0
                      : (neg_q ? x0 - dquo[31:0] : x0 + dquo[31:0]);
        qi_q <= qi_q + 2'd1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = (state_q == S_OUT);
  assign status_o = st_q;
  assign res_time_o = (st_q == StOk && op_q == OpQuery)
                      ? ((lo_q == '0) ? p1_q.t : in_q.t) : 32'd0;
  assign res_dist_o = res_q[0];
  assign res_speed_o = res_q[1];
  assign res_accel_o = res_q[2];
  assign res_jerk_o = res_q[3];
  assign span_time_o = (total_q == '0) ? 32'd0 : last_q - first_q;
  assign stored_count_o = 9'(total_q);

  `SPTI_ASSERT(a_stall_busy, (state_q != S_IDLE) |-> in_stall_o)
  `SPTI_ASSERT(a_count_max, total_q <= CntW'(MaxPoints))
  `SPTI_ASSERT(a_hold_out, (out_valid_o && out_stall_i) |=> out_valid_o)
  `SPTI_ASSERT_RST(a_rst_idle, !rst_ni |=> (state_q == S_IDLE))
endmodule
